### src/ppfa_pkg.sv
// Shared constants, status codes and helpers for the page frame allocator.
// No dependencies.
`timescale 1ns / 1ps

package ppfa_pkg;

   // Map word geometry: each RAM word holds the used bits of WORD_W pages.
   localparam int WORD_W     = 64;
   localparam int WORD_LOG   = 6;
   localparam int PAGE_SHIFT = 12;
   localparam int ADDR_W     = 32;
   localparam int COUNT_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int STATUS_W   = 2;

   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [WORD_W-1:0]   map_word_type;
   typedef logic [WORD_LOG-1:0] bit_idx_type;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NO_MEMORY = 2'd1;
   localparam status_type ST_OUTSIDE   = 2'd2;
   localparam status_type ST_NOT_USED  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT  = 2'd1;

   // Lowest clear bit of a map word; the caller checks that one exists.
   function automatic bit_idx_type first_zero(input map_word_type word);
      bit_idx_type idx;
      idx = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!word[b]) idx = bit_idx_type'(b);
      end
      return idx;
   endfunction

endpackage

### src/ppfa_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ppfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/physical_page_frame_allocator.sv
// First-fit physical page frame allocator: top level and sequencer.
// Depends on ppfa_pkg and ppfa_ram (packed used-bit map).
//
//   channel | direction | ports                                  | handshake
//   req     | in        | req_mode, req_free_address             | req_valid / req_ready
//   rsp     | out       | rsp_page_address, rsp_status           | rsp_valid / rsp_ready
//   csr     | in        | csr_index, csr_wdata                   | csr_valid / csr_ready
//
// Allocate streams the map one 64-page word per cycle from page 0; the single map read
// port sets that rate. Free runs address check, map read, clear and result in order;
// an address outside the region goes from the check straight to the result.
// After reset a clearing pass writes every map word; req_ready stays low meanwhile.
// Control registers reset (state to CLEAR, the rest to 0); the data registers do not.
// A finished result waits in the rsp register; a new request is taken meanwhile.
`timescale 1ns / 1ps

module physical_page_frame_allocator #(
   parameter int MAX_PAGES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  ppfa_pkg::addr_type            req_free_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ppfa_pkg::addr_type            rsp_page_address,
   output ppfa_pkg::status_type          rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ppfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  ppfa_pkg::addr_type            csr_wdata
);

   import ppfa_pkg::*;

   localparam int WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW    = $clog2(WORDS + 1);
   localparam int LIM_W = $clog2(MAX_PAGES + 1);
   localparam int CNT_W = ((LIM_W > WORD_LOG) ? LIM_W : WORD_LOG) + 1;

   typedef enum logic [2:0] {
      CLEAR, IDLE, ALLOC, ALLOC_ADDR, FREE_IDX, FREE_CHK, DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [AW-1:0]      chk_ptr_ff, chk_ptr_in;
   bit_idx_type        bit_ff, bit_in;
   addr_type           free_addr_ff, free_addr_in;
   addr_type           res_addr_ff, res_addr_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   addr_type           rsp_addr_ff, rsp_addr_in;
   status_type         rsp_status_ff, rsp_status_in;
   addr_type           base_ff, base_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   map_word_type       ram_wdata, ram_rdata;

   logic [LIM_W-1:0]   limit;
   logic [CNT_W-1:0]   lim_ext, nwords, last_word;
   logic [WORD_LOG-1:0] rem;
   logic               partial;
   map_word_type       masked;
   bit_idx_type        fz;
   logic               found;
   addr_type           diff;
   logic               outside;

   ppfa_ram #(
      .WIDTH(WORD_W),
      .DEPTH(WORDS)
   ) u_map (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Usable page count and scan geometry.
   always_comb begin
      if (32'(count_ff) > 32'(MAX_PAGES)) limit = LIM_W'(MAX_PAGES);
      else limit = LIM_W'(count_ff);
      lim_ext   = CNT_W'(limit);
      nwords    = (lim_ext + CNT_W'(WORD_W - 1)) >> WORD_LOG;
      last_word = nwords - CNT_W'(1);
      rem       = lim_ext[WORD_LOG-1:0];
      partial   = (CNT_W'(chk_ptr_ff) == last_word) && (rem != '0);
      for (int b = 0; b < WORD_W; b++) begin
         masked[b] = ram_rdata[b] | (partial && (WORD_LOG'(b) >= rem));
      end
      fz    = first_zero(masked);
      found = chk_valid_ff && !(&masked);
      diff    = free_addr_ff - base_ff;
      outside = (free_addr_ff < base_ff) ||
                ({12'b0, diff[ADDR_W-1:PAGE_SHIFT]} >= ADDR_W'(limit));
   end

   assign req_ready        = (state_ff == IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      chk_valid_in  = chk_valid_ff;
      chk_ptr_in    = chk_ptr_ff;
      bit_in        = bit_ff;
      free_addr_in  = free_addr_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      ram_we        = 1'b0;
      ram_waddr     = chk_ptr_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = ptr_ff[AW-1:0];

      // drop the response beat once taken
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_REGION_BASE) base_in = csr_wdata;
         else if (csr_index == CSR_PAGE_COUNT) count_in = csr_wdata[COUNT_W-1:0];
      end

      unique case (state_ff)
         CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[AW-1:0];
            ram_wdata = '0;
            ptr_in    = ptr_ff + CW'(1);
            if (ptr_ff == CW'(WORDS - 1)) state_in = IDLE;
         end
         IDLE: begin
            if (req_valid) begin
               free_addr_in = req_free_address;
               ptr_in       = '0;
               chk_valid_in = 1'b0;
               state_in     = (req_mode == MODE_FREE) ? FREE_IDX : ALLOC;
            end
         end
         ALLOC: begin
            if (found) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata | (map_word_type'(1) << fz);
               bit_in    = fz;
               state_in  = ALLOC_ADDR;
            end else if (!chk_valid_ff && CNT_W'(ptr_ff) >= nwords) begin
               res_addr_in   = '0;
               res_status_in = ST_NO_MEMORY;
               state_in      = DONE;
            end else if (CNT_W'(ptr_ff) < nwords) begin
               ptr_in       = ptr_ff + CW'(1);
               chk_valid_in = 1'b1;
               chk_ptr_in   = ptr_ff[AW-1:0];
            end else begin
               chk_valid_in = 1'b0;
            end
         end
         ALLOC_ADDR: begin
            res_addr_in   = base_ff + (ADDR_W'({chk_ptr_ff, bit_ff}) << PAGE_SHIFT);
            res_status_in = ST_OK;
            state_in      = DONE;
         end
         FREE_IDX: begin
            res_addr_in = '0;
            ram_raddr   = diff[PAGE_SHIFT+WORD_LOG +: AW];
            chk_ptr_in  = diff[PAGE_SHIFT+WORD_LOG +: AW];
            bit_in      = diff[PAGE_SHIFT +: WORD_LOG];
            if (outside) begin
               res_status_in = ST_OUTSIDE;
               state_in      = DONE;
            end else begin
               state_in = FREE_CHK;
            end
         end
         FREE_CHK: begin
            if (ram_rdata[bit_ff]) begin
               ram_we        = 1'b1;
               ram_wdata     = ram_rdata & ~(map_word_type'(1) << bit_ff);
               res_status_in = ST_OK;
            end else begin
               res_status_in = ST_NOT_USED;
            end
            state_in = DONE;
         end
         DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         ptr_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
      end
      chk_ptr_ff    <= chk_ptr_in;
      bit_ff        <= bit_in;
      free_addr_ff  <= free_addr_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_fail_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_page_address == '0))
      else $error("failed request returned a nonzero page address");

   a_alloc_takes_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ALLOC && ram_we) |-> !ram_rdata[fz])
      else $error("allocation marked a page that was already in use");

   a_map_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == CLEAR || state_ff == ALLOC || state_ff == FREE_CHK))
      else $error("map written outside clear, allocate or free");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one still in work");

endmodule

### tb/sv/ppfa_frame_checker.sv
// Spare register indexes, result beat type and the scoreboard for the page frame allocator.
// Depends on ppfa_pkg; the bench top instantiates ppfa_frame_checker beside the block.
`timescale 1ns / 1ps

package ppfa_tb_pkg;

   // Register indexes that the block decodes to nothing.
   localparam logic [ppfa_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [ppfa_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      ppfa_pkg::addr_type   page_address;
      ppfa_pkg::status_type status;
   } frame_result_type;

endpackage

module ppfa_frame_checker #(
   parameter int MAX_PAGES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_mode,
   input  ppfa_pkg::addr_type             req_free_address,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  ppfa_pkg::addr_type             rsp_page_address,
   input  ppfa_pkg::status_type           rsp_status,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [ppfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  ppfa_pkg::addr_type             csr_wdata,
   output int                             mismatches,
   output int                             outstanding
);

   import ppfa_pkg::*;
   import ppfa_tb_pkg::*;

   logic               frame_used [MAX_PAGES];
   addr_type           base_reg;
   logic [COUNT_W-1:0] count_reg;
   frame_result_type   expected_frames [$];
   int                 beat_no;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      beat_no     = 0;
   end

   // First-fit allocate or checked free against the shadow map.
   function automatic frame_result_type predict_frame_result(input logic mode,
                                                             input addr_type addr);
      frame_result_type r;
      int unsigned      usable;
      int unsigned      idx;
      bit               found;
      r.page_address = '0;
      usable = (count_reg > MAX_PAGES) ? MAX_PAGES : count_reg;
      found  = 1'b0;
      if (mode == MODE_ALLOC) begin
         r.status = ST_NO_MEMORY;
         for (int i = 0; i < usable && !found; i++) begin
            if (!frame_used[i]) begin
               frame_used[i]  = 1'b1;
               r.page_address = base_reg + addr_type'(i << PAGE_SHIFT);
               r.status       = ST_OK;
               found          = 1'b1;
            end
         end
      end else if (addr < base_reg) begin
         r.status = ST_OUTSIDE;
      end else begin
         idx = (addr - base_reg) >> PAGE_SHIFT;
         if (idx >= usable) begin
            r.status = ST_OUTSIDE;
         end else if (!frame_used[idx]) begin
            r.status = ST_NOT_USED;
         end else begin
            frame_used[idx] = 1'b0;
            r.status        = ST_OK;
         end
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t rsp beat %0d: %s expected %h, got %h", $realtime, beat_no, what,
                  want, got);
   endtask

   always @(posedge clock) begin : track
      frame_result_type want;
      if (reset) begin
         for (int p = 0; p < MAX_PAGES; p++) frame_used[p] = 1'b0;
         base_reg  = '0;
         count_reg = '0;
         expected_frames.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REGION_BASE: base_reg  = csr_wdata;
               CSR_PAGE_COUNT:  count_reg = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         // Retire the result beat before queueing a request taken on the same edge.
         if (rsp_valid && rsp_ready) begin
            beat_no++;
            if (expected_frames.size() == 0) begin
               flag_mismatch("unexpected beat, page_address", '0, rsp_page_address);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_page_address !== want.page_address)
                  flag_mismatch("page_address", want.page_address, rsp_page_address);
               if (rsp_status !== want.status)
                  flag_mismatch("status", 32'(want.status), 32'(rsp_status));
            end
         end
         if (req_valid && req_ready)
            expected_frames.push_back(predict_frame_result(req_mode, req_free_address));
      end
      outstanding = expected_frames.size();
   end

endmodule

### tb/sv/tb_physical_page_frame_allocator.sv
// Bench top for physical_page_frame_allocator: clock, reset, request and register stimulus.
// Depends on ppfa_pkg, ppfa_tb_pkg and ppfa_frame_checker (ppfa_frame_checker.sv).
`timescale 1ns / 1ps

module tb_physical_page_frame_allocator;
   import ppfa_pkg::*;
   import ppfa_tb_pkg::*;

   localparam int MAP_DEPTH      = 4096;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int TAIL_CYCLES    = 80;
   localparam int PHASE_ITEMS    = 85;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_mode;
   addr_type             req_free_address;
   logic                 rsp_valid;
   logic                 rsp_ready;
   addr_type             rsp_page_address;
   status_type           rsp_status;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   addr_type             csr_wdata;
   int                   mismatches;
   int                   outstanding;

   // Stimulus knobs for the sender, the receiver and the address picks.
   int                   send_idle_max;
   int                   rsp_idle_max;
   bit                   rsp_long_hold;
   addr_type             cfg_base;
   logic [COUNT_W-1:0]   cfg_count;

   physical_page_frame_allocator #(.MAX_PAGES(MAP_DEPTH)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_page_address (rsp_page_address),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   ppfa_frame_checker #(.MAX_PAGES(MAP_DEPTH)) frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_page_address (rsp_page_address),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input addr_type data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx == CSR_REGION_BASE) cfg_base = data;
      if (idx == CSR_PAGE_COUNT) cfg_count = data[COUNT_W-1:0];
   endtask

   // Idle for a random gap, then hold the beat until it is taken.
   task automatic send_frame_request(input logic mode, input addr_type addr);
      int gap;
      gap = $urandom_range(send_idle_max, 0);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_mode         = mode;
      req_free_address = addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_all_answered();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Receiver: random hold-off per beat, plus one long hold on request.
   initial begin : receiver
      int wait_cycles;
      rsp_ready = 1'b0;
      forever begin
         if (rsp_long_hold) begin
            wait_cycles   = LONG_HOLD;
            rsp_long_hold = 1'b0;
         end else begin
            wait_cycles = $urandom_range(rsp_idle_max, 0);
         end
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_ready = 1'b0;
         end
         @(negedge clock);
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Abort when no channel moves a beat for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("physical_page_frame_allocator test failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned  usable;
      int unsigned  span;
      int unsigned  pick;
      logic         mode;
      addr_type     addr;
      logic [12:0]  count_choice;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_ALLOC;
      req_free_address = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_REGION_BASE;
      csr_wdata        = '0;
      send_idle_max    = 6;
      rsp_idle_max     = 6;
      rsp_long_hold    = 1'b0;
      cfg_base         = '0;
      cfg_count        = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty region straight out of reset.
      send_frame_request(MODE_ALLOC, 32'h0000_0000);
      send_frame_request(MODE_FREE, 32'h0000_0000);
      wait_all_answered();

      // Three pages; upper bits of the count write must be dropped.
      write_reg(CSR_REGION_BASE, 32'h0010_0000);
      write_reg(CSR_PAGE_COUNT, 32'hFFFF_E003);
      repeat (4) send_frame_request(MODE_ALLOC, 32'hFFFF_FFFF);
      send_frame_request(MODE_FREE, 32'h0010_1123);
      send_frame_request(MODE_FREE, 32'h0010_1FFF);
      send_frame_request(MODE_FREE, 32'h000F_FFFF);
      send_frame_request(MODE_FREE, 32'h0010_3000);
      send_frame_request(MODE_FREE, 32'hFFFF_FFFF);
      send_frame_request(MODE_ALLOC, 32'h0000_0000);
      wait_all_answered();

      // Count above map depth, base at the top so addresses wrap.
      write_reg(CSR_REGION_BASE, 32'hFFFF_E000);
      write_reg(CSR_PAGE_COUNT, 32'h0000_1FFF);
      send_frame_request(MODE_ALLOC, 32'h0000_0000);
      send_frame_request(MODE_FREE, 32'hFFFF_F000);
      send_frame_request(MODE_FREE, 32'h0000_1000);
      send_frame_request(MODE_ALLOC, 32'h0000_0000);
      wait_all_answered();

      // Unaligned base; spare indexes must not disturb anything.
      write_reg(CSR_REGION_BASE, 32'h0000_0ABC);
      write_reg(CSR_PAGE_COUNT, 32'h0000_0002);
      write_reg(CSR_SPARE_2, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_3, 32'h5A5A_A5A5);
      send_frame_request(MODE_ALLOC, 32'h0000_0000);
      send_frame_request(MODE_FREE, 32'h0000_1ABB);
      send_frame_request(MODE_ALLOC, 32'h0000_0000);
      send_frame_request(MODE_FREE, 32'h0000_2ABC);
      wait_all_answered();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: count_choice = 13'd8191;
            1: count_choice = 13'd5;
            2: count_choice = 13'd64;
            3: count_choice = 13'd0;
            4: count_choice = 13'd65;
            5: count_choice = 13'd4096;
            6: count_choice = 13'd1;
            7: count_choice = 13'd130;
            8: count_choice = 13'd4096;
            default: count_choice = 13'($urandom_range(8191, 0));
         endcase
         case (phase % 4)
            0: write_reg(CSR_REGION_BASE, 32'hFFFF_F000);
            1: write_reg(CSR_REGION_BASE, 32'h0000_0000);
            2: write_reg(CSR_REGION_BASE, $urandom() & 32'hFFFF_F000);
            default: write_reg(CSR_REGION_BASE, $urandom());
         endcase
         write_reg(CSR_PAGE_COUNT, {19'($urandom()), count_choice});
         write_reg((phase % 2) ? CSR_SPARE_3 : CSR_SPARE_2, $urandom());
         send_idle_max = (phase % 4 == 1 || phase % 4 == 2) ? 0 : 6;
         rsp_idle_max  = (phase % 4 == 2 || phase % 4 == 3) ? 0 : 6;
         usable = (cfg_count > MAP_DEPTH) ? MAP_DEPTH : cfg_count;
         span   = (usable > 160) ? 160 : usable;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Fill the block while the receiver sits idle for a long stretch.
            if (phase == 5 && n == 20) rsp_long_hold = 1'b1;
            if (phase == 7 && n == 40) wait_all_answered();
            pick = $urandom_range(99, 0);
            addr = $urandom();
            mode = MODE_FREE;
            if (pick < 50) begin
               mode = MODE_ALLOC;
            end else if (pick < 85) begin
               // Aim at pages the first-fit scan is likely to have handed out.
               addr = cfg_base + addr_type'($urandom_range(span + 1, 0) << PAGE_SHIFT);
               if ($urandom_range(1, 0)) addr = addr + $urandom_range(4095, 0);
            end else if (pick < 92 && cfg_base != 0) begin
               addr = $urandom_range(cfg_base - 1, 0);
            end
            send_frame_request(mode, addr);
         end
         wait_all_answered();
      end

      while (outstanding != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("physical_page_frame_allocator test passed");
      else
         $display("physical_page_frame_allocator test failed");
      $finish;
   end

endmodule

### files.f
src/ppfa_pkg.sv
src/ppfa_ram.sv
src/physical_page_frame_allocator.sv
tb/sv/ppfa_frame_checker.sv
tb/sv/tb_physical_page_frame_allocator.sv
